// File: rtl/szos_pkg.sv
package szos_pkg;

  localparam int ZONES      = 5;
  localparam int RANGE_W    = 16;
  localparam int MODE_W     = 3;
  localparam int SPEED_W    = 16;
  localparam int NUM_RAYS_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_RAYS   = 5;

  typedef logic [RANGE_W-1:0]        range_t;
  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RAYS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_DIST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_SPEED = 3'd5;

  // register reset values
  localparam logic [NUM_RAYS_W-1:0] NUM_RAYS_RST  = 13'd360;
  localparam range_t                MAX_RANGE_RST = 16'd65535;
  localparam range_t                SAFETY_RST    = 16'd500;
  localparam logic                  REVERSE_RST   = 1'b1;
  localparam speed_t                LIN_SPEED_RST = 16'sd300;
  localparam speed_t                ANG_SPEED_RST = 16'sd200;

  localparam speed_t SPEED_MIN = 16'sh8000;
  localparam speed_t SPEED_MAX = 16'sh7fff;

  // drive modes
  localparam mode_t MODE_SEEK     = 3'd0;
  localparam mode_t MODE_LEFT     = 3'd1;
  localparam mode_t MODE_STRAIGHT = 3'd2;
  localparam mode_t MODE_SLOW     = 3'd3;
  localparam mode_t MODE_REVERSE  = 3'd4;

  // blocked-zone pattern (bit k = zone k blocked) to drive mode
  localparam mode_t MODE_TABLE [32] = '{
    MODE_SEEK,     MODE_STRAIGHT, MODE_LEFT,     MODE_LEFT,
    MODE_LEFT,     MODE_LEFT,     MODE_LEFT,     MODE_LEFT,
    MODE_SEEK,     MODE_SLOW,     MODE_SLOW,     MODE_SLOW,
    MODE_LEFT,     MODE_LEFT,     MODE_LEFT,     MODE_LEFT,
    MODE_SEEK,     MODE_SLOW,     MODE_SLOW,     MODE_LEFT,
    MODE_SEEK,     MODE_LEFT,     MODE_SEEK,     MODE_LEFT,
    MODE_SEEK,     MODE_SEEK,     MODE_SLOW,     MODE_SLOW,
    MODE_LEFT,     MODE_SEEK,     MODE_LEFT,     MODE_REVERSE
  };

  // classified tick handed from front to back
  typedef struct packed {
    logic             tie;
    logic [ZONES-1:0] blocked;
  } tick_t;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

endpackage

// File: rtl/szos_front.sv
module szos_front #(
  parameter int MAX_RAYS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_acc,
  input  logic                         in_cmd,
  input  szos_pkg::range_t             in_range_sample,
  input  logic [$clog2(MAX_RAYS+1)-1:0] eff_n,
  input  szos_pkg::range_t             max_range,
  input  szos_pkg::range_t             safe_dist,
  input  logic                         reverse_order,
  output logic                         tick_push,
  output szos_pkg::tick_t              tick_data
);

  localparam int N_W   = $clog2(MAX_RAYS+1);
  localparam int CNT_W = $clog2(MAX_RAYS);
  localparam int P_W   = N_W + 3;
  localparam int Z     = szos_pkg::ZONES;

  logic [CNT_W-1:0] ray_cnt_r, ray_cnt_nxt;
  logic [P_W-1:0]   c5_r, c5_nxt;      // 5 * (ray_cnt + 1)
  logic             seen_r, seen_nxt;
  szos_pkg::range_t work_min_r [Z];
  szos_pkg::range_t work_min_nxt [Z];
  szos_pkg::range_t work_upd [Z];
  szos_pkg::range_t latch_min_r [Z];
  szos_pkg::range_t latch_min_nxt [Z];

  logic [P_W-1:0] bound [Z-1];   // n * (j+1)
  logic [Z-2:0]   past_bound;
  logic [Z-1:0]   zone_sel;
  logic           sample_acc;
  logic           scan_end;

  // sample i is in zone >= k when 5*(i+1) > n*k
  always_comb begin
    for (int j = 0; j < Z-1; j++) begin
      bound[j]      = P_W'(eff_n) * P_W'(j + 1);
      past_bound[j] = c5_r > bound[j];
    end
    for (int k = 0; k < Z; k++) begin
      if (k == 0) begin
        zone_sel[k] = !past_bound[0];
      end else if (k == Z-1) begin
        zone_sel[k] = past_bound[Z-2];
      end else begin
        zone_sel[k] = past_bound[k-1] & !past_bound[k];
      end
    end
  end

  assign sample_acc = in_acc & !in_cmd;
  assign scan_end   = ((N_W+1)'(ray_cnt_r) + (N_W+1)'(1)) >= (N_W+1)'(eff_n);

  always_comb begin
    ray_cnt_nxt = ray_cnt_r;
    c5_nxt      = c5_r;
    seen_nxt    = seen_r;
    for (int k = 0; k < Z; k++) begin
      work_upd[k]      = work_min_r[k];
      work_min_nxt[k]  = work_min_r[k];
      latch_min_nxt[k] = latch_min_r[k];
    end
    if (sample_acc) begin
      for (int k = 0; k < Z; k++) begin
        if (zone_sel[k] && (in_range_sample < work_min_r[k])) begin
          work_upd[k] = in_range_sample;
        end
        work_min_nxt[k] = work_upd[k];
      end
      if (scan_end) begin
        for (int k = 0; k < Z; k++) begin
          latch_min_nxt[k] = reverse_order ? work_upd[Z-1-k] : work_upd[k];
          work_min_nxt[k]  = max_range;
        end
        ray_cnt_nxt = '0;
        c5_nxt      = P_W'(Z);
        seen_nxt    = 1'b1;
      end else begin
        ray_cnt_nxt = ray_cnt_r + CNT_W'(1);
        c5_nxt      = c5_r + P_W'(Z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_cnt_r <= '0;
      c5_r      <= P_W'(Z);
      seen_r    <= 1'b0;
      for (int k = 0; k < Z; k++) begin
        work_min_r[k]  <= szos_pkg::MAX_RANGE_RST;
        latch_min_r[k] <= szos_pkg::MAX_RANGE_RST;
      end
    end else begin
      ray_cnt_r <= ray_cnt_nxt;
      c5_r      <= c5_nxt;
      seen_r    <= seen_nxt;
      for (int k = 0; k < Z; k++) begin
        work_min_r[k]  <= work_min_nxt[k];
        latch_min_r[k] <= latch_min_nxt[k];
      end
    end
  end

  // tick classification against the latched scan
  always_comb begin
    tick_data.tie = 1'b0;
    for (int k = 0; k < Z; k++) begin
      tick_data.blocked[k] = latch_min_r[k] < safe_dist;
      if (latch_min_r[k] == safe_dist) begin
        tick_data.tie = 1'b1;
      end
    end
  end

  assign tick_push = in_acc & in_cmd & seen_r;

endmodule

// File: rtl/szos_queue.sv
module szos_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  szos_pkg::tick_t din,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output szos_pkg::tick_t dout
);

  localparam int D = szos_pkg::Q_DEPTH;
  localparam int W = szos_pkg::Q_PTR_W;

  szos_pkg::tick_t mem [D];
  logic [W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [W:0]      cnt_r, cnt_nxt;

  assign full      = cnt_r == (W+1)'(D);
  assign not_empty = cnt_r != '0;
  assign dout      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == W'(D-1)) ? '0 : wr_ptr_r + W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == W'(D-1)) ? '0 : rd_ptr_r + W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/szos_back.sv
module szos_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  szos_pkg::tick_t  q_data,
  output logic             q_pop,
  input  szos_pkg::speed_t linear_speed,
  input  szos_pkg::speed_t angular_speed,
  output logic             out_valid,
  input  logic             out_stall,
  output szos_pkg::mode_t  out_drive_mode,
  output szos_pkg::speed_t out_linear_velocity,
  output szos_pkg::speed_t out_angular_velocity
);

  logic             out_valid_r, out_valid_nxt;
  szos_pkg::mode_t  mode_r, mode_nxt;
  szos_pkg::speed_t lin_r, lin_nxt;
  szos_pkg::speed_t ang_r, ang_nxt;
  szos_pkg::speed_t lin_neg;
  logic             load;

  assign load  = q_valid & (!out_valid_r | !out_stall);
  assign q_pop = load;

  // negation saturates at the most negative speed
  assign lin_neg = (linear_speed == szos_pkg::SPEED_MIN) ? szos_pkg::SPEED_MAX : -linear_speed;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    mode_nxt      = mode_r;
    lin_nxt       = lin_r;
    ang_nxt       = ang_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!q_data.tie) begin
        mode_nxt = szos_pkg::MODE_TABLE[q_data.blocked];
      end
      case (mode_nxt)
        szos_pkg::MODE_LEFT: begin
          lin_nxt = '0;
          ang_nxt = angular_speed;
        end
        szos_pkg::MODE_REVERSE: begin
          lin_nxt = lin_neg;
          ang_nxt = angular_speed;
        end
        default: begin
          lin_nxt = linear_speed;
          ang_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= szos_pkg::MODE_SEEK;
    end else begin
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lin_r <= lin_nxt;
    ang_r <= ang_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_drive_mode       = mode_r;
  assign out_linear_velocity  = lin_r;
  assign out_angular_velocity = ang_r;

endmodule

// File: rtl/scan_zone_obstacle_steering_core.sv
// Throughput: one transaction per cycle on the input, samples and ticks alike, while the
//   tick queue is not full; the two-entry tick queue and the output register let each
//   side stall on its own. An accepted tick goes through the queue to the output register.
// Samples give no result; a tick before the first full scan gives none either.
// Reset (rst_n low, synchronous): settings return to their defaults, zone minima to
//   65535, ray counter to 0, no scan seen, drive mode seek, queue and output empty.
module scan_zone_obstacle_steering_core #(
  parameter int MAX_RAYS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample / tick channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  szos_pkg::range_t                    in_range_sample,
  // steering result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output szos_pkg::mode_t                     out_drive_mode,
  output szos_pkg::speed_t                    out_linear_velocity,
  output szos_pkg::speed_t                    out_angular_velocity,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [szos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [szos_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N_W     = $clog2(MAX_RAYS+1);
  localparam int CLAMP_W = (N_W > szos_pkg::NUM_RAYS_W) ? N_W : szos_pkg::NUM_RAYS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [szos_pkg::NUM_RAYS_W-1:0] num_rays_r;
  szos_pkg::range_t                max_range_r;
  szos_pkg::range_t                safety_r;
  logic                            reverse_r;
  szos_pkg::speed_t                lin_speed_r;
  szos_pkg::speed_t                ang_speed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rays_r  <= szos_pkg::NUM_RAYS_RST;
      max_range_r <= szos_pkg::MAX_RANGE_RST;
      safety_r    <= szos_pkg::SAFETY_RST;
      reverse_r   <= szos_pkg::REVERSE_RST;
      lin_speed_r <= szos_pkg::LIN_SPEED_RST;
      ang_speed_r <= szos_pkg::ANG_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        szos_pkg::CFG_NUM_RAYS:      num_rays_r  <= cfg_data[szos_pkg::NUM_RAYS_W-1:0];
        szos_pkg::CFG_MAX_RANGE:     max_range_r <= cfg_data;
        szos_pkg::CFG_SAFE_DIST:     safety_r    <= cfg_data;
        szos_pkg::CFG_REVERSE_ORDER: reverse_r   <= cfg_data[0];
        szos_pkg::CFG_LINEAR_SPEED:  lin_speed_r <= cfg_data;
        szos_pkg::CFG_ANGULAR_SPEED: ang_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective ray count, clamped to [5, MAX_RAYS].
  logic [CLAMP_W-1:0] nr_ext;
  logic [CLAMP_W-1:0] nr_clamp;
  logic [N_W-1:0]     eff_n;

  assign nr_ext = CLAMP_W'(num_rays_r);

  always_comb begin
    if (nr_ext < CLAMP_W'(szos_pkg::MIN_RAYS)) begin
      nr_clamp = CLAMP_W'(szos_pkg::MIN_RAYS);
    end else if (nr_ext > CLAMP_W'(MAX_RAYS)) begin
      nr_clamp = CLAMP_W'(MAX_RAYS);
    end else begin
      nr_clamp = nr_ext;
    end
  end

  assign eff_n = N_W'(nr_clamp);

  // ---------------------------------------------------------------------------
  // Front: zone minima tracking and tick classification.
  // Back:  mode table, mode hold on ties, velocity selection, output register.
  // ---------------------------------------------------------------------------
  logic            in_acc;
  logic            tick_push;
  szos_pkg::tick_t tick_data;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  szos_pkg::tick_t q_data;

  // Stall only when the tick queue is full.
  assign in_stall = q_full;
  assign in_acc   = in_valid & !in_stall;

  szos_front #(
    .MAX_RAYS(MAX_RAYS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .in_cmd          (in_cmd),
    .in_range_sample (in_range_sample),
    .eff_n           (eff_n),
    .max_range       (max_range_r),
    .safe_dist       (safety_r),
    .reverse_order   (reverse_r),
    .tick_push       (tick_push),
    .tick_data       (tick_data)
  );

  szos_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick_push),
    .din       (tick_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_data)
  );

  szos_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_not_empty),
    .q_data               (q_data),
    .q_pop                (q_pop),
    .linear_speed         (lin_speed_r),
    .angular_speed        (ang_speed_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive_mode       (out_drive_mode),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import szos_pkg::*;

  localparam int MAX_RAYS     = 4096;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 4;     // tick-to-result path through queue and output register, plus margin
  localparam int RAND_PER_PROFILE = 520;
  localparam int LONG_SCAN_RAYS   = 300;

  // input transaction kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    mode_t  mode;
    speed_t lin;
    speed_t ang;
  } steer_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TICK, ROW_CFG} row_kind_e;

  // directed rows; typed rows carry a hand-written expectation
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic                   typed;
    logic                   has_res;
    steer_t                 res;
  } dir_row_t;

  localparam steer_t NO_STEER    = '0;
  // all zones blocked, linear speed -32768 negated saturates, angular -32768
  localparam steer_t SAT_REVERSE = '{MODE_REVERSE, SPEED_MAX, SPEED_MIN};

  // blocked pattern (bit k = zone k) to drive mode
  localparam mode_t STEER_MAP [32] = '{
    MODE_SEEK, MODE_STRAIGHT, MODE_LEFT, MODE_LEFT,
    MODE_LEFT, MODE_LEFT,     MODE_LEFT, MODE_LEFT,
    MODE_SEEK, MODE_SLOW,     MODE_SLOW, MODE_SLOW,
    MODE_LEFT, MODE_LEFT,     MODE_LEFT, MODE_LEFT,
    MODE_SEEK, MODE_SLOW,     MODE_SLOW, MODE_LEFT,
    MODE_SEEK, MODE_LEFT,     MODE_SEEK, MODE_LEFT,
    MODE_SEEK, MODE_SEEK,     MODE_SLOW, MODE_SLOW,
    MODE_LEFT, MODE_SEEK,     MODE_LEFT, MODE_REVERSE
  };

  // Directed part, all with 5-ray scans (ray count 0 acts as 5):
  // tick before any scan, all-blocked scan with speed extremes,
  // a zone equal to the safety distance (mode held), then one near
  // obstacle in zone 0 with and without zone reversal.
  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_CFG,    CFG_NUM_RAYS,      16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_CFG,    CFG_LINEAR_SPEED,  16'h8000,  1'b0, 1'b0, NO_STEER},
    '{ROW_CFG,    CFG_ANGULAR_SPEED, 16'h8000,  1'b0, 1'b0, NO_STEER},
    '{ROW_TICK,   '0,                16'hffff,  1'b1, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_TICK,   '0,                16'd0,     1'b1, 1'b1, SAT_REVERSE},
    '{ROW_SAMPLE, '0,                16'd600,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd600,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd500,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd600,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd600,   1'b0, 1'b0, NO_STEER},
    '{ROW_TICK,   '0,                16'h5555,  1'b1, 1'b1, SAT_REVERSE},
    '{ROW_SAMPLE, '0,                16'd100,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_TICK,   '0,                16'haaaa,  1'b0, 1'b0, NO_STEER},
    '{ROW_CFG,    CFG_REVERSE_ORDER, 16'd0,     1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'd100,   1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_SAMPLE, '0,                16'hffff,  1'b0, 1'b0, NO_STEER},
    '{ROW_TICK,   '0,                16'd0,     1'b0, 1'b0, NO_STEER}
  };

  // DUT ports; every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_cmd = CMD_SAMPLE;
  range_t                in_range_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  mode_t                 out_drive_mode;
  speed_t                out_linear_velocity;
  speed_t                out_angular_velocity;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NUM_RAYS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow registers of the steering core
  logic [12:0] rays_cfg;
  range_t      max_rng;
  range_t      safety;
  logic        rev_zones;
  speed_t      lin_spd;
  speed_t      ang_spd;

  // shadow scan state
  int          ray_cnt;
  range_t      work_min  [ZONES];
  range_t      latch_min [ZONES];
  bit          scan_seen;
  mode_t       cur_mode;

  // obstacle layout planned for the scan being streamed
  logic [ZONES-1:0] plan_blocked;
  int               plan_tie;

  steer_t steer_pending [$];   // steering results still owed by the core

  int snd_idle_pct  = 18;
  int rcv_stall_pct = 81;
  int cycles;
  int fail_cnt;
  int xfers_in;
  int steers_checked;
  int scans_latched;
  int cfg_writes;

  scan_zone_obstacle_steering_core #(
    .MAX_RAYS(MAX_RAYS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_range_sample      (in_range_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive_mode       (out_drive_mode),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ray count register is clamped to 5 .. MAX_RAYS
  function automatic int eff_rays();
    if (rays_cfg < MIN_RAYS) return MIN_RAYS;
    if (rays_cfg > MAX_RAYS) return MAX_RAYS;
    return int'(rays_cfg);
  endfunction

  // zone k spans rays floor(N*k/5) .. floor(N*(k+1)/5)-1
  function automatic int zone_at(input int ray);
    int n;
    int z;
    n = eff_rays();
    z = 0;
    for (int k = 1; k < ZONES; k++)
      if (ray >= (n * k) / ZONES) z = k;
    return z;
  endfunction

  // Advance the shadow core by one input transaction; returns 1 when a
  // steering result is owed.
  function automatic bit steer_step(input logic cmd, input range_t smp,
                                    output steer_t res);
    int          z;
    bit          tie;
    logic [ZONES-1:0] blocked;
    res = NO_STEER;
    if (cmd == CMD_SAMPLE) begin
      z = zone_at(ray_cnt);
      if (smp < work_min[z]) work_min[z] = smp;
      // a lowered ray count mid-scan ends the scan on the next sample
      if (ray_cnt >= eff_rays() - 1) begin
        for (int k = 0; k < ZONES; k++)
          latch_min[k] = rev_zones ? work_min[ZONES-1-k] : work_min[k];
        for (int k = 0; k < ZONES; k++) work_min[k] = max_rng;
        ray_cnt   = 0;
        scan_seen = 1'b1;
        scans_latched++;
      end else begin
        ray_cnt++;
      end
      return 1'b0;
    end
    if (!scan_seen) return 1'b0;
    tie     = 1'b0;
    blocked = '0;
    for (int k = 0; k < ZONES; k++) begin
      if (latch_min[k] == safety) tie = 1'b1;
      if (latch_min[k] < safety) blocked[k] = 1'b1;
    end
    // any zone exactly at the threshold holds the previous mode
    if (!tie) cur_mode = STEER_MAP[blocked];
    res.mode = cur_mode;
    case (cur_mode)
      MODE_LEFT: begin
        res.lin = '0;
        res.ang = ang_spd;
      end
      MODE_REVERSE: begin
        res.lin = (lin_spd == SPEED_MIN) ? SPEED_MAX : -lin_spd;
        res.ang = ang_spd;
      end
      default: begin
        res.lin = lin_spd;
        res.ang = '0;
      end
    endcase
    return 1'b1;
  endfunction

  // Range sample for the current ray. At scan start a fresh obstacle layout
  // is drawn: blocked zones get readings under the threshold, one zone may
  // sit exactly on it, the rest read clear, with some plain noise mixed in.
  function automatic range_t pick_sample();
    int z;
    int r;
    int hi;
    if (ray_cnt == 0) begin
      plan_blocked = ZONES'($urandom);
      plan_tie     = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, ZONES - 1)) : -1;
    end
    z = zone_at(ray_cnt);
    r = $urandom_range(0, 99);
    if (r < 8) return range_t'($urandom);
    if (plan_blocked[z] && r < 60 && safety != 0)
      return range_t'($urandom_range(0, int'(safety) - 1));
    if (plan_tie == z && r < 50) return safety;
    if (safety == 16'hffff) return safety;
    hi = (r < 75) ? int'(safety) + 300 : 65535;
    if (hi > 65535) hi = 65535;
    return range_t'($urandom_range(int'(safety) + 1, hi));
  endfunction

  function automatic speed_t rand_speed();
    case ($urandom_range(0, 9))
      0:       return SPEED_MIN;
      1:       return SPEED_MAX;
      2:       return 16'sh8001;
      3:       return '0;
      default: return speed_t'($urandom);
    endcase
  endfunction

  // One input transaction. Valid stays up after acceptance until the next
  // falling edge decides to idle or present the next item.
  task automatic send_item(input logic cmd, input range_t smp, input bit typed,
                           input bit typed_has, input steer_t typed_res);
    steer_t pred;
    bit     has;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_range_sample <= smp;
    do @(posedge clk); while (in_stall);
    xfers_in++;
    has = steer_step(cmd, smp, pred);
    if (typed) begin
      has  = typed_has;
      pred = typed_res;
    end
    if (has) steer_pending.push_back(pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_NUM_RAYS:      rays_cfg  = val[12:0];
      CFG_MAX_RANGE:     max_rng   = val;
      CFG_SAFE_DIST:     safety    = val;
      CFG_REVERSE_ORDER: rev_zones = val[0];
      CFG_LINEAR_SPEED:  lin_spd   = speed_t'(val);
      CFG_ANGULAR_SPEED: ang_spd   = speed_t'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every owed result, then let the pipe empty
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (steer_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);

  // scoreboard: each accepted result against the oldest owed one
  always @(posedge clk) begin : score
    steer_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (steer_pending.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: mode %0d lin %0d ang %0d",
                   out_drive_mode, out_linear_velocity, out_angular_velocity);
      end else begin
        exp_s = steer_pending.pop_front();
        steers_checked++;
        if (out_drive_mode !== exp_s.mode || out_linear_velocity !== exp_s.lin ||
            out_angular_velocity !== exp_s.ang) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d: exp mode/lin/ang %0d/%0d/%0d, got %0d/%0d/%0d",
                     steers_checked, exp_s.mode, exp_s.lin, exp_s.ang,
                     out_drive_mode, out_linear_velocity, out_angular_velocity);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d cycles, %0d results still owed", cycles, steer_pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int               sent;
    int               plen;
    int               ticks_owed;
    int               scans_prev;
    int               r;
    logic [CFG_DATA_W-1:0] v;

    // shadow state at reset
    rays_cfg  = 13'd360;
    max_rng   = 16'd65535;
    safety    = 16'd500;
    rev_zones = 1'b1;
    lin_spd   = 16'sd300;
    ang_spd   = 16'sd200;
    ray_cnt   = 0;
    for (int k = 0; k < ZONES; k++) begin
      work_min[k]  = 16'd65535;
      latch_min[k] = 16'd65535;
    end
    scan_seen  = 1'b0;
    cur_mode   = MODE_SEEK;
    plan_tie   = -1;
    ticks_owed = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (DIR_TAB[i].kind)
        ROW_CFG: begin
          settle_idle();
          write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
        end
        ROW_SAMPLE: send_item(CMD_SAMPLE, DIR_TAB[i].val, 1'b0, 1'b0, NO_STEER);
        default:    send_item(CMD_TICK, DIR_TAB[i].val, DIR_TAB[i].typed,
                              DIR_TAB[i].has_res, DIR_TAB[i].res);
      endcase
    end

    // Random part in three idle profiles: slow receiver, slow sender, none.
    // Each phase reprograms every register, so scans left unfinished run on
    // under a new ray count (lowered counts end them early).
    for (int m = 0; m < 3; m++) begin
      snd_idle_pct  = (m == 0) ? 18 : (m == 1) ? 81 : 0;
      rcv_stall_pct = (m == 0) ? 81 : (m == 1) ? 18 : 0;
      sent = 0;
      while (sent < RAND_PER_PROFILE) begin
        settle_idle();
        r = $urandom_range(0, 99);
        if (r < 10)      v = 16'($urandom_range(0, 4));
        else if (r < 75) v = 16'($urandom_range(5, 24));
        else if (r < 95) v = 16'($urandom_range(25, 400));
        else             v = 16'($urandom_range(401, 8191));
        write_reg(CFG_NUM_RAYS, v);
        r = $urandom_range(0, 99);
        if (r < 10)      v = 16'd0;
        else if (r < 20) v = 16'hffff;
        else if (r < 45) v = 16'($urandom_range(0, 1000));
        else             v = 16'($urandom);
        write_reg(CFG_SAFE_DIST, v);
        r = $urandom_range(0, 99);
        if (r < 50)      v = 16'hffff;
        else if (r < 70) v = 16'($urandom);
        else if (r < 80) v = safety;
        else             v = 16'($urandom_range(0, 1000));
        write_reg(CFG_MAX_RANGE, v);
        write_reg(CFG_REVERSE_ORDER, 16'($urandom_range(0, 1)));
        write_reg(CFG_LINEAR_SPEED, rand_speed());
        write_reg(CFG_ANGULAR_SPEED, rand_speed());

        plen = $urandom_range(40, 200);
        for (int i = 0; i < plen && sent < RAND_PER_PROFILE; i++) begin
          if (ticks_owed > 0) begin
            ticks_owed--;
            send_item(CMD_TICK, range_t'($urandom), 1'b0, 1'b0, NO_STEER);
          end else if ($urandom_range(0, 99) < 6) begin
            // stray tick in the middle of a scan
            send_item(CMD_TICK, range_t'($urandom), 1'b0, 1'b0, NO_STEER);
          end else begin
            scans_prev = scans_latched;
            send_item(CMD_SAMPLE, pick_sample(), 1'b0, 1'b0, NO_STEER);
            if (scans_latched != scans_prev) ticks_owed = $urandom_range(0, 3);
          end
          sent++;
        end
      end
    end

    // long scan at the largest ray count (register above the maximum), then
    // the count drops to 5 so the next sample ends it
    settle_idle();
    write_reg(CFG_NUM_RAYS, 16'd8191);
    repeat (LONG_SCAN_RAYS) send_item(CMD_SAMPLE, pick_sample(), 1'b0, 1'b0, NO_STEER);
    settle_idle();
    write_reg(CFG_NUM_RAYS, 16'd5);
    scans_prev = scans_latched;
    while (scans_latched == scans_prev)
      send_item(CMD_SAMPLE, pick_sample(), 1'b0, 1'b0, NO_STEER);
    repeat (2) send_item(CMD_TICK, range_t'($urandom), 1'b0, 1'b0, NO_STEER);

    settle_idle();
    $display("%0d input transactions, %0d scans latched, %0d steering results checked",
             xfers_in, scans_latched, steers_checked);
    $display("%0d register writes: ray counts 0..8191, both zone orders, speed extremes",
             cfg_writes);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
